/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pic_pkg.sv */
`timescale 1ns / 1ps
package pic_pkg;
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_LEVEL  = 2'd2;
	localparam logic [25:0] PENDING_BASE = 26'h000_1000;
	localparam logic [25:0] ENAB_BASE  = 26'h000_2000;
	localparam logic [25:0] CONTEXT_BASE = 26'h020_0000;
	localparam logic [2:0] PRIO_MASK   = 3'h7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [25:0] address;
		logic [3:0]  access_bytes;
		logic [31:0] write_data;
		logic [4:0]  source;
		logic        level;
	} pic_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        machine_irq;
		logic        supervisor_irq;
	} pic_out_t;

	// byte mask for an access size
	function automatic logic [31:0] size_mask(input logic [3:0] n);
		logic [31:0] m;
		m = 32'hFFFF_FFFF;
		case (n)
			4'd0: m = 32'h0;
			4'd1: m = 32'h0000_00FF;
			4'd2: m = 32'h0000_FFFF;
			4'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction
endpackage

/* rtl/platform_interrupt_controller.sv */
`timescale 1ns / 1ps
// steps from accept to result valid: apply the transaction, scan the sources in turn, finish;
// a claim then hands out the winner and rescans once for the irq flags
// no new transaction is taken until the result has been taken at the output;
// the scan over the source priorities runs through one shared compare unit
// reset: all priorities, pending, enables, thresholds and claims clear to zero
module platform_interrupt_controller import pic_pkg::*; #(
	parameter int NUM_SOURCES   = 32,
	parameter int NUM_TARGETS   = 2,
	parameter int TARGET_STRIDE = 4096,
	parameter int ENABLE_STRIDE = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pic_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pic_out_t out_data
);
	`include "assert_macros.svh"

	localparam int SW = $clog2(NUM_SOURCES);
	localparam int WORDS = (NUM_SOURCES + 31) / 32;
	localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int TS = $clog2(TARGET_STRIDE);
	localparam int ES = $clog2(ENABLE_STRIDE);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	pic_in_t req_q;
	logic [2:0] prio_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] pend_q;
	logic [NUM_SOURCES-1:0] en_q [2];
	logic [2:0] thr_q [2];
	logic [SW-1:0] claim_q [2];
	logic [SW:0] idx_q;
	logic [SW-1:0] best_q [2];
	logic [2:0] bestp_q [2];
	logic claim_op_q;
	logic claim_t_q;
	logic [31:0] rdata_q;

	// address decode
	logic [25:0] a;
	logic [31:0] mask;
	logic [4:0] sh;
	logic [25:0] rp, re, rc;
	logic [25:0] te, tc;
	logic [SW+1:0] ps;
	logic [25:0] pw, ew, ec, cc;
	logic prio_hit, pend_hit, en_hit, ctx_hit;
	logic [31:0] prio_word, pend_word, en_word, cur_word;

	always_comb begin
		a = req_q.address;
		mask = size_mask(req_q.access_bytes);
		sh = {a[1:0], 3'b000};
		rp = a - PENDING_BASE;
		re = a - ENAB_BASE;
		rc = a - CONTEXT_BASE;
		te = re >> ES;
		ec = re & 26'(ENABLE_STRIDE - 1);
		tc = rc >> TS;
		cc = rc & 26'(TARGET_STRIDE - 1);
		pw = rp >> 2;
		ew = ec >> 2;
		ps = (SW+2)'(a >> 2);
		prio_hit = (a < PENDING_BASE) && ((a >> 2) < 26'(NUM_SOURCES));
		pend_hit = (a >= PENDING_BASE) && (a < ENAB_BASE) && (pw < 26'(WORDS));
		en_hit = (a >= ENAB_BASE) && (a < CONTEXT_BASE) && (te < 26'(NUM_TARGETS))
			&& (ew < 26'(WORDS));
		ctx_hit = (a >= CONTEXT_BASE) && (tc < 26'(NUM_TARGETS));
		prio_word = '0;
		if (prio_hit)
			prio_word = {29'd0, prio_q[ps[SW-1:0]]};
		pend_word = '0;
		en_word = '0;
		for (int b = 0; b < 32; b++) begin
			if (pw * 32 + b < NUM_SOURCES)
				pend_word[b] = pend_q[pw[WW-1:0] * 32 + b];
			if (ew * 32 + b < NUM_SOURCES)
				en_word[b] = en_q[te[0]][ew[WW-1:0] * 32 + b];
		end
		cur_word = prio_hit ? prio_word : en_word;
	end

	// one shared compare unit over the sources
	logic [SW-1:0] sidx;
	logic qual [2];
	assign sidx = idx_q[SW-1:0];
	always_comb begin
		for (int t = 0; t < 2; t++)
			qual[t] = (idx_q != 0) && (t < NUM_TARGETS) && pend_q[sidx] && en_q[t][sidx]
				&& (prio_q[sidx] > thr_q[t]) && (prio_q[sidx] > bestp_q[t]);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data.read_data = rdata_q;
	assign out_data.machine_irq = (best_q[0] != '0);
	assign out_data.supervisor_irq = (NUM_TARGETS > 1) && (best_q[1] != '0);

	logic [31:0] merged, ctx_rd;
	always_comb begin
		merged = (cur_word & ~(mask << sh)) | ((req_q.write_data & mask) << sh);
		ctx_rd = '0;
		if (cc == 26'd0)
			ctx_rd = {29'd0, thr_q[tc[0]]} & mask;
		else if (cc == 26'd4)
			ctx_rd = 32'(claim_q[tc[0]]) & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= '0;
			for (int s = 0; s < NUM_SOURCES; s++)
				prio_q[s] <= '0;
			for (int t = 0; t < 2; t++) begin
				en_q[t] <= '0;
				thr_q[t] <= '0;
				claim_q[t] <= '0;
				best_q[t] <= '0;
				bestp_q[t] <= '0;
			end
			idx_q <= '0;
			claim_op_q <= 1'b0;
			claim_t_q <= 1'b0;
			rdata_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						state_q <= ST_SCAN;
						idx_q <= '1;
					end
				end
				ST_SCAN: begin
					// apply the transaction on the first scan cycle
					if (idx_q == '1) begin
						claim_op_q <= 1'b0;
						rdata_q <= '0;
						idx_q <= '0;
						for (int t = 0; t < 2; t++) begin
							best_q[t] <= '0;
							bestp_q[t] <= '0;
						end
						case (req_q.kind)
							KIND_READ: begin
								if (prio_hit)
									rdata_q <= (prio_word >> sh) & mask;
								else if (pend_hit)
									rdata_q <= (pend_word >> sh) & mask;
								else if (en_hit)
									rdata_q <= (en_word >> sh) & mask;
								else if (ctx_hit) begin
									rdata_q <= ctx_rd;
									if (cc == 26'd4 && req_q.access_bytes == 4'd4) begin
										claim_op_q <= 1'b1;
										claim_t_q <= tc[0];
										for (int t = 0; t < 2; t++)
											bestp_q[t] <= thr_q[tc[0]];
									end
								end
							end
							KIND_WRITE: begin
								if (prio_hit)
									prio_q[ps[SW-1:0]] <= merged[2:0] & PRIO_MASK;
								else if (en_hit) begin
									for (int b = 0; b < 32; b++)
										if (ew * 32 + b < NUM_SOURCES)
											en_q[te[0]][ew[WW-1:0] * 32 + b] <= merged[b];
								end else if (ctx_hit) begin
									if (cc == 26'd0)
										thr_q[tc[0]] <= ((thr_q[tc[0]] & ~mask[2:0])
											| (req_q.write_data[2:0] & mask[2:0]));
									else if (cc == 26'd4 && req_q.access_bytes == 4'd4
										&& req_q.write_data != 0
										&& 32'(claim_q[tc[0]]) == req_q.write_data)
										claim_q[tc[0]] <= '0;
								end
							end
							KIND_LEVEL: begin
								if (req_q.source != 0 && 32'(req_q.source) < NUM_SOURCES)
									pend_q[req_q.source[SW-1:0]] <= req_q.level;
							end
							default: ;
						endcase
					end else begin
						for (int t = 0; t < 2; t++)
							if (qual[t]) begin
								best_q[t] <= sidx;
								bestp_q[t] <= prio_q[sidx];
							end
						if (idx_q == (SW+1)'(NUM_SOURCES - 1))
							state_q <= ST_FIN;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (claim_op_q) begin
						// claim: hand out the winner, then rescan for the irq flags
						claim_q[claim_t_q] <= best_q[claim_t_q];
						rdata_q <= 32'(best_q[claim_t_q]);
						pend_q[best_q[claim_t_q]] <= 1'b0;
						claim_op_q <= 1'b0;
						idx_q <= '0;
						for (int t = 0; t < 2; t++) begin
							best_q[t] <= '0;
							bestp_q[t] <= '0;
						end
						state_q <= ST_SCAN;
					end else
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "state not one-hot")
	`ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(rdata_q),
		"result dropped")
	`ASSERT_ALWAYS(a_ready_excl, !(in_ready && out_valid), "ready during result")
endmodule

/* tb/tb_platform_interrupt_controller.sv */
`timescale 1ns / 1ps
module tb_platform_interrupt_controller;
	import pic_pkg::*;

	localparam int N_SRC = 32;
	localparam int N_TGT = 2;
	localparam int T_STRIDE = 4096;
	localparam int E_STRIDE = 128;
	localparam logic [25:0] CTX_END = 26'h3FF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pic_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pic_out_t out_data;

	// shadow copy of the controller state
	logic [2:0] prio_q [N_SRC];
	logic [31:0] pend_q;
	logic [31:0] enab_q [N_TGT];
	logic [2:0] thr_q [N_TGT];
	logic [4:0] claim_q [N_TGT];

	pic_out_t expected_q [$];
	int mismatches = 0;
	bit quiet = 1'b0;

	platform_interrupt_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] lane_mask(logic [3:0] n);
		if (n == 4'd0) return 32'h0;
		if (n >= 4'd4) return 32'hFFFF_FFFF;
		return (32'h1 << (8 * n)) - 32'h1;
	endfunction

	function automatic logic [31:0] lane_merge(logic [31:0] cur, logic [31:0] val,
			logic [31:0] m, int sh);
		return (cur & ~(m << sh)) | ((val & m) << sh);
	endfunction

	// winner of the claim arbitration for one target
	function automatic logic [4:0] winning_source(int t);
		logic [4:0] best;
		logic [2:0] best_p;
		best = '0;
		best_p = '0;
		for (int s = 1; s < N_SRC; s++) begin
			if (pend_q[s] && enab_q[t][s] && prio_q[s] > thr_q[t] && prio_q[s] > best_p) begin
				best_p = prio_q[s];
				best = 5'(s);
			end
		end
		return best;
	endfunction

	function automatic logic [31:0] predict_read(logic [25:0] off, logic [3:0] n);
		logic [31:0] m;
		int r, t, co, sh;
		logic [4:0] s;
		m = lane_mask(n);
		if (off < PENDING_BASE) begin
			if (off / 4 < N_SRC) return ({29'b0, prio_q[off / 4]} >> ((off % 4) * 8)) & m;
		end else if (off < ENAB_BASE) begin
			r = off - PENDING_BASE;
			if (r / 4 < 1) return (pend_q >> ((r % 4) * 8)) & m;
		end else if (off < CONTEXT_BASE) begin
			r = off - ENAB_BASE;
			t = r / E_STRIDE;
			co = r % E_STRIDE;
			sh = (co % 4) * 8;
			if (t < N_TGT && co / 4 < 1) return (enab_q[t] >> sh) & m;
		end else begin
			r = off - CONTEXT_BASE;
			t = r / T_STRIDE;
			co = r % T_STRIDE;
			if (t < N_TGT) begin
				if (co == 0) return {29'b0, thr_q[t]} & m;
				if (co == 4) begin
					if (n == 4'd4) begin
						s = winning_source(t);
						if (s != 0) pend_q[s] = 1'b0;
						claim_q[t] = s;
						return {27'b0, s} & m;
					end
					return {27'b0, claim_q[t]} & m;
				end
			end
		end
		return 32'h0;
	endfunction

	function automatic void apply_write(logic [25:0] off, logic [3:0] n, logic [31:0] v);
		logic [31:0] m;
		int r, t, co;
		m = lane_mask(n);
		if (off < PENDING_BASE) begin
			if (off / 4 < N_SRC)
				prio_q[off / 4] = 3'(lane_merge({29'b0, prio_q[off / 4]}, v, m, (off % 4) * 8));
		end else if (off < ENAB_BASE) begin
			// pending is read only
		end else if (off < CONTEXT_BASE) begin
			r = off - ENAB_BASE;
			t = r / E_STRIDE;
			co = r % E_STRIDE;
			if (t < N_TGT && co / 4 < 1) enab_q[t] = lane_merge(enab_q[t], v, m, (co % 4) * 8);
		end else begin
			r = off - CONTEXT_BASE;
			t = r / T_STRIDE;
			co = r % T_STRIDE;
			if (t < N_TGT) begin
				if (co == 0) thr_q[t] = 3'(lane_merge({29'b0, thr_q[t]}, v, m, 0));
				else if (co == 4 && n == 4'd4 && v != 0 && {27'b0, claim_q[t]} == v)
					claim_q[t] = '0;
			end
		end
	endfunction

	function automatic pic_out_t predict(pic_in_t x);
		pic_out_t o;
		o = '0;
		case (x.kind)
			KIND_READ: o.read_data = predict_read(x.address, x.access_bytes);
			KIND_WRITE: apply_write(x.address, x.access_bytes, x.write_data);
			KIND_LEVEL: if (x.source != 0) pend_q[x.source] = x.level;
			default: ;
		endcase
		o.machine_irq = winning_source(0) != 0;
		o.supervisor_irq = winning_source(1) != 0;
		return o;
	endfunction

	// send one transaction and record what it should produce
	task automatic send(pic_in_t x);
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(predict(x));
	endtask

	task automatic rd(logic [25:0] a, logic [3:0] n);
		pic_in_t x;
		x = '0;
		x.kind = KIND_READ;
		x.address = a;
		x.access_bytes = n;
		x.write_data = $urandom;
		send(x);
	endtask

	task automatic wr(logic [25:0] a, logic [3:0] n, logic [31:0] v);
		pic_in_t x;
		x = '0;
		x.kind = KIND_WRITE;
		x.address = a;
		x.access_bytes = n;
		x.write_data = v;
		send(x);
	endtask

	task automatic line(logic [4:0] s, logic l);
		pic_in_t x;
		x = '0;
		x.kind = KIND_LEVEL;
		x.source = s;
		x.level = l;
		x.address = 26'($urandom);
		send(x);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", out_data);
				end else begin
					pic_out_t e;
					e = expected_q.pop_front();
					if (e.read_data !== out_data.read_data ||
							e.machine_irq !== out_data.machine_irq ||
							e.supervisor_irq !== out_data.supervisor_irq) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h/%b/%b got %h/%b/%b",
								e.read_data, e.machine_irq, e.supervisor_irq,
								out_data.read_data, out_data.machine_irq,
								out_data.supervisor_irq);
					end
				end
			end
		end
	end

	task automatic test_directed();
		wr(26'h4, 4'd4, 32'hFFFF_FFFF);
		wr(26'h8, 4'd1, 32'h3);
		wr(26'h7C, 4'd2, 32'h6);
		rd(26'h4, 4'd4);
		rd(26'h5, 4'd1);
		wr(ENAB_BASE, 4'd4, 32'hFFFF_FFFF);
		wr(26'(ENAB_BASE + E_STRIDE + 1), 4'd1, 32'hA5);
		rd(26'(ENAB_BASE + E_STRIDE), 4'd4);
		line(5'd0, 1'b1);
		line(5'd1, 1'b1);
		line(5'd2, 1'b1);
		line(5'd31, 1'b1);
		wr(PENDING_BASE, 4'd4, 32'h0);
		rd(PENDING_BASE, 4'd8);
		wr(CONTEXT_BASE, 4'd4, 32'h2);
		rd(26'(CONTEXT_BASE + 4), 4'd4);
		rd(26'(CONTEXT_BASE + 4), 4'd2);
		wr(26'(CONTEXT_BASE + 4), 4'd4, 32'h5);
		wr(26'(CONTEXT_BASE + 4), 4'd2, 32'h1F);
		wr(26'(CONTEXT_BASE + 4), 4'd4, 32'h1F);
		rd(26'(CONTEXT_BASE + T_STRIDE + 4), 4'd4);
		rd(26'(CONTEXT_BASE + 2 * T_STRIDE), 4'd4);
		rd(26'h3FF_FFFF, 4'd0);
		wr(26'(CONTEXT_BASE + T_STRIDE), 4'd15, 32'h7);
		rd(26'h80, 4'd4);
	endtask

	function automatic logic [25:0] random_address();
		int t;
		t = $urandom_range(N_TGT);
		case ($urandom_range(9))
			0, 1: return 26'($urandom_range(130));
			2: return 26'(PENDING_BASE + $urandom_range(7));
			3, 4: return 26'(ENAB_BASE + t * E_STRIDE + $urandom_range(7));
			5: return 26'(CONTEXT_BASE + t * T_STRIDE + $urandom_range(5));
			6, 7: return 26'(CONTEXT_BASE + $urandom_range(1) * T_STRIDE + 4);
			8: return 26'($urandom);
			default: return 26'(CTX_END - $urandom_range(3));
		endcase
	endfunction

	task automatic test_random(int count);
		pic_in_t x;
		for (int i = 0; i < count; i++) begin
			quiet = (i >= count / 3 && i < count / 2);
			x.kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
			x.address = random_address();
			x.access_bytes = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd4;
			x.write_data = ($urandom_range(1)) ? $urandom : $urandom_range(31);
			x.source = 5'($urandom);
			x.level = 1'($urandom);
			send(x);
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int s = 0; s < N_SRC; s++) prio_q[s] = '0;
		pend_q = '0;
		for (int t = 0; t < N_TGT; t++) begin
			enab_q[t] = '0;
			thr_q[t] = '0;
			claim_q[t] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1100);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2 * N_SRC + 10) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
